/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dclc_pkg.sv */
package dclc_pkg;

  localparam int DCLC_CHANNELS = 4;

  typedef logic [2:0] fw_state_t;
  typedef logic [2:0] task_state_t;

  // commands
  localparam logic [3:0] M_INIT     = 4'd0;
  localparam logic [3:0] M_STARTUP  = 4'd1;
  localparam logic [3:0] M_SHUTDOWN = 4'd2;
  localparam logic [3:0] M_FINALIZE = 4'd3;
  localparam logic [3:0] M_FW_QUERY = 4'd4;
  localparam logic [3:0] M_CREATE   = 4'd5;
  localparam logic [3:0] M_DESTROY  = 4'd6;
  localparam logic [3:0] M_START    = 4'd7;
  localparam logic [3:0] M_STOP     = 4'd8;
  localparam logic [3:0] M_TQUERY   = 4'd9;
  localparam logic [3:0] M_FRAME    = 4'd10;
  localparam logic [3:0] M_RELEASE  = 4'd11;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BAD    = 3'd1;
  localparam logic [2:0] ST_NA     = 3'd2;
  localparam logic [2:0] ST_NOMORE = 3'd3;
  localparam logic [2:0] ST_NOINIT = 3'd4;

  // firmware states
  localparam fw_state_t FW_NOT_INIT  = 3'd0;
  localparam fw_state_t FW_POWER_OFF = 3'd1;
  localparam fw_state_t FW_BOOTING   = 3'd2;
  localparam fw_state_t FW_READY     = 3'd3;
  localparam fw_state_t FW_RUNNING   = 3'd4;
  localparam fw_state_t FW_SHUTTING  = 3'd5;
  localparam fw_state_t FW_SHUT_DOWN = 3'd6;

  // channel states
  localparam task_state_t TK_UNUSED   = 3'd0;
  localparam task_state_t TK_PREPARED = 3'd1;
  localparam task_state_t TK_STARTING = 3'd2;
  localparam task_state_t TK_DECODING = 3'd3;
  localparam task_state_t TK_STOPPING = 3'd4;

  // processor status
  localparam logic [1:0] PS_BOOTING  = 2'd1;
  localparam logic [1:0] PS_READY    = 2'd2;
  localparam logic [1:0] PS_SHUTDOWN = 2'd3;

  // mailbox commands
  localparam logic [2:0] MB_NONE     = 3'd0;
  localparam logic [2:0] MB_START    = 3'd1;
  localparam logic [2:0] MB_STOP     = 3'd2;
  localparam logic [2:0] MB_SHUTDOWN = 3'd3;
  localparam logic [2:0] MB_RELEASED = 3'd4;
  localparam logic [2:0] MB_EOD      = 3'd5;

  typedef struct packed {
    logic [3:0] mode;
    logic [1:0] channel;
    logic       channel_valid;
    logic [7:0] unit_id;
    logic       args_ok;
    logic       version_ok;
    logic [1:0] fw0_status;
    logic [1:0] fw1_status;
    logic [3:0] run_bitstream_mask;
    logic [3:0] run_video_mask;
    logic       output_ready;
    logic       output_end;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    fw_state_t   fw_state_out;
    task_state_t task_state_out;
    logic [1:0]  channel_out;
    logic        frame_available;
    logic [2:0]  mailbox_command;
  } rsp_t;

endpackage

/* rtl/dclc_step.sv */
module dclc_step #(
  parameter int CHANNELS = dclc_pkg::DCLC_CHANNELS
) (
  input  dclc_pkg::cmd_t                         cmd,
  input  dclc_pkg::fw_state_t                    fw,
  input  logic [CHANNELS-1:0]                    used,
  input  dclc_pkg::task_state_t [CHANNELS-1:0]   ts,
  input  logic [CHANNELS-1:0]                    ie,
  input  logic [CHANNELS-1:0]                    oe,
  output dclc_pkg::fw_state_t                    fw_next,
  output logic [CHANNELS-1:0]                    used_next,
  output dclc_pkg::task_state_t [CHANNELS-1:0]   ts_next,
  output logic [CHANNELS-1:0]                    ie_next,
  output logic [CHANNELS-1:0]                    oe_next,
  output dclc_pkg::rsp_t                         rsp
);
  import dclc_pkg::*;

  logic [CHANNELS+3:0]            bs_ext, vd_ext;
  logic [CHANNELS-1:0]            bs, vd;
  logic [CHANNELS-1:0]            sel_all, sel, out_sel;
  logic [CHANNELS-1:0]            go_dec, go_prep, dec_orig, dec_after;
  logic [CHANNELS-1:0]            alloc_oh;
  task_state_t [CHANNELS-1:0]     ts_poll, pf_ts, sp_ts;
  logic                           has_ch, unit_bad, fw_ok;
  logic                           used_ch, ie_ch, oe_ch;
  task_state_t                    ts_ch, ts_poll_ch, ts_out;
  logic                           full_ready, none_dec, sp_ready;
  fw_state_t                      pf_fw, sp_fw;
  logic [1:0]                     ch_alloc, ch_out;
  logic [2:0]                     st, mb;
  logic                           avail;

  assign bs_ext = {{CHANNELS{1'b0}}, cmd.run_bitstream_mask};
  assign vd_ext = {{CHANNELS{1'b0}}, cmd.run_video_mask};
  assign bs     = bs_ext[CHANNELS-1:0];
  assign vd     = vd_ext[CHANNELS-1:0];

  // lowest free channel
  assign alloc_oh = ~used & (used + CHANNELS'(1));

  assign has_ch   = cmd.channel_valid && (32'(cmd.channel) < CHANNELS);
  assign unit_bad = |cmd.unit_id;
  assign fw_ok    = (fw == FW_READY) || (fw == FW_RUNNING);

  // per-channel poll terms and selected-channel lookups
  always_comb begin
    used_ch    = 1'b0;
    ie_ch      = 1'b0;
    oe_ch      = 1'b0;
    ts_ch      = TK_UNUSED;
    ts_poll_ch = TK_UNUSED;
    ch_alloc   = 2'd0;
    full_ready = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      sel_all[c]   = (32'(cmd.channel) == c);
      sel[c]       = has_ch && sel_all[c];
      go_dec[c]    = (ts[c] == TK_STARTING) && bs[c] && vd[c];
      go_prep[c]   = (ts[c] == TK_STOPPING) && !bs[c] && !vd[c];
      dec_orig[c]  = (ts[c] == TK_DECODING);
      dec_after[c] = dec_orig[c] || go_dec[c];
      ts_poll[c]   = go_dec[c] ? TK_DECODING : (go_prep[c] ? TK_PREPARED : ts[c]);
      pf_ts[c]     = (fw == FW_RUNNING) ? ts_poll[c] : ts[c];
      sp_ts[c]     = sel[c] ? ts_poll[c] : ts[c];
      if (sel[c]) begin
        used_ch    = used[c];
        ie_ch      = ie[c];
        oe_ch      = oe[c];
        ts_ch      = ts[c];
        ts_poll_ch = ts_poll[c];
      end
      if (alloc_oh[c]) begin
        ch_alloc = 2'(c);
      end
    end
    // full poll walks channels upward: lower ones already updated, higher ones not
    for (int c = 0; c < CHANNELS; c++) begin
      none_dec = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
        if ((i < c && dec_after[i]) || (i > c && dec_orig[i])) begin
          none_dec = 1'b0;
        end
      end
      if (go_prep[c] && none_dec) begin
        full_ready = 1'b1;
      end
    end
  end

  assign sp_ready = (|(go_prep & sel)) && !(|dec_orig);
  assign sp_fw    = sp_ready ? FW_READY : fw;

  always_comb begin
    pf_fw = fw;
    case (fw)
      FW_BOOTING, FW_POWER_OFF: begin
        if (cmd.fw0_status == PS_READY && cmd.fw1_status == PS_READY) begin
          pf_fw = FW_READY;
        end else if (cmd.fw0_status == PS_BOOTING || cmd.fw1_status == PS_BOOTING) begin
          pf_fw = FW_BOOTING;
        end
      end
      FW_SHUTTING: begin
        if (cmd.fw0_status == PS_SHUTDOWN && cmd.fw1_status == PS_SHUTDOWN) begin
          pf_fw = FW_SHUT_DOWN;
        end
      end
      FW_RUNNING: begin
        if (full_ready) begin
          pf_fw = FW_READY;
        end
      end
      default: pf_fw = fw;
    endcase
  end

  always_comb begin
    fw_next   = fw;
    used_next = used;
    ts_next   = ts;
    ie_next   = ie;
    oe_next   = oe;
    st        = ST_OK;
    mb        = MB_NONE;
    avail     = 1'b0;
    out_sel   = sel_all;
    ch_out    = cmd.channel;
    case (cmd.mode)
      M_INIT: begin
        if (fw != FW_NOT_INIT) begin
          st = ST_NA;
        end else if (!cmd.args_ok) begin
          st = ST_BAD;
        end else if (!cmd.version_ok) begin
          st = ST_NA;
        end else begin
          used_next = '0;
          ts_next   = '0;
          ie_next   = '0;
          oe_next   = '0;
          fw_next   = FW_POWER_OFF;
        end
      end
      M_STARTUP: begin
        if (unit_bad) begin
          st = ST_BAD;
        end else if (fw != FW_POWER_OFF) begin
          st = ST_NA;
        end else begin
          fw_next = FW_BOOTING;
        end
      end
      M_SHUTDOWN: begin
        if (unit_bad) begin
          st = ST_BAD;
        end else if (fw != FW_READY || (|used)) begin
          st = ST_NA;
        end else begin
          mb      = MB_SHUTDOWN;
          fw_next = FW_SHUTTING;
        end
      end
      M_FINALIZE: begin
        if (fw != FW_SHUT_DOWN) begin
          st = ST_NA;
        end else begin
          fw_next = FW_NOT_INIT;
        end
      end
      M_FW_QUERY: begin
        if (unit_bad || !cmd.args_ok) begin
          st = ST_BAD;
        end else begin
          fw_next = pf_fw;
          ts_next = pf_ts;
        end
      end
      M_CREATE: begin
        if (unit_bad || !cmd.args_ok) begin
          st = ST_BAD;
        end else begin
          fw_next = pf_fw;
          ts_next = pf_ts;
          if (pf_fw != FW_READY && pf_fw != FW_RUNNING) begin
            st = ST_NA;
          end else if (!(|alloc_oh)) begin
            st = ST_NOMORE;
          end else begin
            for (int c = 0; c < CHANNELS; c++) begin
              if (alloc_oh[c]) begin
                used_next[c] = 1'b1;
                ts_next[c]   = TK_PREPARED;
              end
            end
            out_sel = alloc_oh;
            ch_out  = ch_alloc;
          end
        end
      end
      M_DESTROY: begin
        if (!cmd.args_ok || !has_ch) begin
          st = ST_BAD;
        end else if (!used_ch || !fw_ok || ts_ch != TK_PREPARED) begin
          st = ST_NA;
        end else begin
          used_next = used & ~sel;
          for (int c = 0; c < CHANNELS; c++) begin
            if (sel[c]) begin
              ts_next[c] = TK_UNUSED;
            end
          end
        end
      end
      M_START: begin
        if (fw == FW_NOT_INIT) begin
          st = ST_NOINIT;
        end else if (!cmd.args_ok || !has_ch) begin
          st = ST_BAD;
        end else if (!used_ch || !fw_ok || ts_ch != TK_PREPARED) begin
          st = ST_NA;
        end else begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (sel[c]) begin
              ts_next[c] = TK_STARTING;
            end
          end
          ie_next = ie & ~sel;
          oe_next = oe & ~sel;
          fw_next = FW_RUNNING;
          mb      = MB_START;
        end
      end
      M_STOP: begin
        if (fw == FW_NOT_INIT) begin
          st = ST_NOINIT;
        end else if (!cmd.args_ok || !has_ch || !used_ch) begin
          st = ST_BAD;
        end else if (fw != FW_RUNNING || ts_ch != TK_DECODING) begin
          st = ST_NA;
        end else begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (sel[c]) begin
              ts_next[c] = TK_STOPPING;
            end
          end
          mb = MB_STOP;
        end
      end
      M_TQUERY: begin
        if (!cmd.args_ok || !has_ch) begin
          st = ST_BAD;
        end else begin
          fw_next = sp_fw;
          ts_next = sp_ts;
        end
      end
      M_FRAME: begin
        if (!cmd.args_ok || !has_ch) begin
          st = ST_BAD;
        end else if (fw == FW_NOT_INIT) begin
          st = ST_NOINIT;
        end else begin
          fw_next = sp_fw;
          ts_next = sp_ts;
          if (sp_fw != FW_RUNNING || ts_poll_ch != TK_DECODING) begin
            st = ST_NA;
          end else begin
            avail = cmd.output_ready && !oe_ch;
          end
        end
      end
      M_RELEASE: begin
        if (!cmd.args_ok || !has_ch) begin
          st = ST_BAD;
        end else if (!cmd.output_ready && cmd.output_end) begin
          // input end-of-data marker
          if (ie_ch) begin
            st = ST_NA;
          end else begin
            fw_next = sp_fw;
            ts_next = sp_ts;
            if (sp_fw != FW_RUNNING || ts_poll_ch != TK_DECODING) begin
              st = ST_NA;
            end else begin
              ie_next = ie | sel;
              mb      = MB_EOD;
            end
          end
        end else begin
          fw_next = sp_fw;
          ts_next = sp_ts;
          if (sp_fw != FW_RUNNING || ts_poll_ch != TK_DECODING || !cmd.output_ready) begin
            st = ST_NA;
          end else begin
            if (cmd.output_end) begin
              oe_next = oe | sel;
            end
            mb = MB_RELEASED;
          end
        end
      end
      default: st = ST_NA;
    endcase
  end

  always_comb begin
    ts_out = TK_UNUSED;
    for (int c = 0; c < CHANNELS; c++) begin
      if (out_sel[c]) begin
        ts_out = ts_next[c];
      end
    end
  end

  assign rsp.status          = st;
  assign rsp.fw_state_out    = fw_next;
  assign rsp.task_state_out  = ts_out;
  assign rsp.channel_out     = ch_out;
  assign rsp.frame_available = avail;
  assign rsp.mailbox_command = mb;

endmodule

/* rtl/decoder_channel_lifecycle_controller_unit.sv */
// Decoder channel lifecycle controller.
// cmd channel (cmd_valid/cmd_ready, cmd): one command per transfer, with the
//   polled processor status and the per-channel running masks.
// rsp channel (rsp_valid/rsp_ready, rsp): one result per command, in order:
//   status, firmware state, channel state, channel, frame flag, mailbox code.
// Pipeline: a command accepted into the input register (cmd_q) passes through
//   the transition logic into the result register (rsp), which sets rsp_valid;
//   it moves on only while the result register is empty or being read.
// Throughput: one command per cycle while rsp is not stalled; the firmware state
//   and channel table are updated in that same single pass, so back-to-back
//   commands see each other's effects.
// Reset (rst, synchronous): firmware goes to not initialized, the channel
//   table is cleared, both pipeline registers are emptied.
// Stall: while rsp is held, the input register still takes one more command;
//   after that cmd_ready drops until the result is taken.
module decoder_channel_lifecycle_controller_unit #(
  parameter int CHANNELS = dclc_pkg::DCLC_CHANNELS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  dclc_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dclc_pkg::rsp_t rsp
);
  import dclc_pkg::*;

  cmd_t                        cmd_q;
  logic                        cmd_q_valid;
  logic                        advance;
  fw_state_t                   fw, fw_next;
  logic [CHANNELS-1:0]         used, used_next;
  task_state_t [CHANNELS-1:0]  ts, ts_next;
  logic [CHANNELS-1:0]         ie, ie_next;
  logic [CHANNELS-1:0]         oe, oe_next;
  rsp_t                        rsp_next;

  assign advance   = cmd_q_valid && (!rsp_valid || rsp_ready);
  assign cmd_ready = !cmd_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      cmd_q_valid <= 1'b1;
    end else if (advance) begin
      cmd_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_q <= cmd;
    end
  end

  dclc_step #(.CHANNELS(CHANNELS)) u_step (
    .cmd       (cmd_q),
    .fw        (fw),
    .used      (used),
    .ts        (ts),
    .ie        (ie),
    .oe        (oe),
    .fw_next   (fw_next),
    .used_next (used_next),
    .ts_next   (ts_next),
    .ie_next   (ie_next),
    .oe_next   (oe_next),
    .rsp       (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fw   <= FW_NOT_INIT;
      used <= '0;
      ts   <= '0;
      ie   <= '0;
      oe   <= '0;
    end else if (advance) begin
      fw   <= fw_next;
      used <= used_next;
      ts   <= ts_next;
      ie   <= ie_next;
      oe   <= oe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* rtl/dclc_checker.sv */
`include "assert_macros.svh"

module dclc_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input dclc_pkg::cmd_t cmd,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input dclc_pkg::rsp_t rsp
);
  import dclc_pkg::*;

  logic cmd_stall, rsp_stall;
  logic is_start, start_ok;
  logic is_stop, stop_ok;
  logic is_frame, frame_ok;

  assign cmd_stall = cmd_valid && !cmd_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;

  assign is_start = rsp_valid && rsp.mailbox_command == MB_START;
  assign start_ok = rsp.status == ST_OK && rsp.fw_state_out == FW_RUNNING &&
                    rsp.task_state_out == TK_STARTING;
  assign is_stop  = rsp_valid && rsp.mailbox_command == MB_STOP;
  assign stop_ok  = rsp.status == ST_OK && rsp.task_state_out == TK_STOPPING;
  assign is_frame = rsp_valid && rsp.frame_available;
  assign frame_ok = rsp.status == ST_OK && rsp.mailbox_command == MB_NONE &&
                    rsp.task_state_out == TK_DECODING;

  `ASSERT_NXT(a_rsp_hold, clk, rst, rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

  `ASSERT_IMP(a_start, clk, rst, is_start, start_ok, "start without running channel")

  `ASSERT_IMP(a_stop, clk, rst, is_stop, stop_ok, "stop without stopping channel")

  `ASSERT_IMP(a_frame, clk, rst, is_frame, frame_ok, "frame flag on idle channel")

  `ASSERT_NXT(a_cmd_hold, clk, rst, cmd_stall, cmd_valid && $stable(cmd), "waiting command changed")

endmodule

bind decoder_channel_lifecycle_controller_unit dclc_checker u_dclc_checker (.*);
